### rtl/cpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpa_pkg: shared types and constants of the contiguous page allocator
// Page map geometry, command, status and register codes, and the
// request, result and page entry records passed between modules.
// ----------------------------------------------------------------------------
package cpa_pkg;

    // Page map geometry (index fields are 10 bits, so at most 1024 pages)
    localparam int MAP_DEPTH = 1024;
    localparam int PAGE_W    = 10;
    localparam int CNT_W     = PAGE_W + 1;

    localparam logic [PAGE_W-1:0] PAGE_LAST = PAGE_W'(MAP_DEPTH - 1);

    // Command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_BAD      = 2'd2;

    // Configuration register indexes
    localparam logic CFG_TOTAL_PAGES   = 1'b0;
    localparam logic CFG_RESERVED_LAST = 1'b1;

    // One page map entry
    typedef struct packed {
        logic used;
        logic run_start;
        logic run_end;
    } page_entry_t;

    localparam int ENTRY_W = $bits(page_entry_t);

    typedef struct packed {
        logic              cmd;
        logic [CNT_W-1:0]  page_count;
        logic [PAGE_W-1:0] page_index;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [PAGE_W-1:0] first_page;
        logic [CNT_W-1:0]  pages_freed;
    } res_t;

endpackage

### rtl/contiguous_page_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contiguous_page_allocator: first-fit contiguous page allocator
// Page map of 1024 entries (used, run start, run end) held in one RAM,
// with a stream request port, a stream result port and a config port.
// ----------------------------------------------------------------------------
// Usage: after reset the block sweeps all 1024 page map entries to zero,
// during which s_tready stays low (configuration writes are taken at once).
// Each request then runs alone, one map entry per cycle through the single
// RAM read port. An allocate of n pages whose run ends at page L scans the
// map up to L, then writes one entry per page of the run; one that fails
// scans the whole map. A free of a run of r pages writes each of its r
// entries. A bad request answers without touching the map.
// The next request is taken as soon as the sequencer is idle, even while
// the previous result still waits in the output register.
// ----------------------------------------------------------------------------
module contiguous_page_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    // Request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [10:0] page_count, [20:11] page_index, rest zero
    input  logic        s_tuser,   // [0] cmd (0 allocate, 1 free)
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [1:0] status, [11:2] first_page, [22:12] pages_freed
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_addr,
    input  logic [10:0] cfg_data
);

    logic [cpa_pkg::CNT_W-1:0]  total_pages_reg;
    logic [cpa_pkg::PAGE_W-1:0] reserved_last_reg;
    logic [cpa_pkg::CNT_W-1:0]  map_size;

    cpa_pkg::req_t       req;
    cpa_pkg::res_t       res;
    cpa_pkg::res_t       out_reg;
    logic                out_valid_reg, out_valid_next;
    logic                res_valid;
    logic                res_free;

    logic                       wr_en;
    logic [cpa_pkg::PAGE_W-1:0] wr_addr;
    cpa_pkg::page_entry_t       wr_data;
    logic [cpa_pkg::PAGE_W-1:0] rd_addr;
    cpa_pkg::page_entry_t       rd_data;
    logic [cpa_pkg::ENTRY_W-1:0] rd_bits;

    // Configuration: always ready; the user must write only while idle, the block does not enforce it
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_pages_reg   <= cpa_pkg::CNT_W'(cpa_pkg::MAP_DEPTH);
            reserved_last_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_addr)
                cpa_pkg::CFG_TOTAL_PAGES:   total_pages_reg   <= cfg_data;
                cpa_pkg::CFG_RESERVED_LAST: reserved_last_reg <= cfg_data[cpa_pkg::PAGE_W-1:0];
                default: ;
            endcase
        end
    end

    // Clip the managed size to the map depth
    assign map_size = (total_pages_reg > cpa_pkg::CNT_W'(cpa_pkg::MAP_DEPTH))
                    ? cpa_pkg::CNT_W'(cpa_pkg::MAP_DEPTH) : total_pages_reg;

    // Unpack the request transaction
    assign req.cmd        = s_tuser;
    assign req.page_count = s_tdata[10:0];
    assign req.page_index = s_tdata[20:11];

    // Output register: load a finished result when the slot is empty or draining
    assign res_free = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (res_valid) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        if (res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg.pages_freed, out_reg.first_page, out_reg.status};

    cpa_engine u_engine (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .map_size      (map_size),
        .reserved_last (reserved_last_reg),
        .req_valid     (s_tvalid),
        .req_ready     (s_tready),
        .req           (req),
        .res_valid     (res_valid),
        .res_free      (res_free),
        .res           (res),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data)
    );

    // Page map: one entry per page, read data registered
    cpa_ram #(
        .WIDTH (cpa_pkg::ENTRY_W),
        .DEPTH (cpa_pkg::MAP_DEPTH)
    ) u_map (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_bits)
    );

    assign rd_data = cpa_pkg::page_entry_t'(rd_bits);

    // A result is never loaded over one that is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && out_valid_reg) |-> m_tready)
        else $error("result loaded over a waiting result");

    // The request port is not ready when reset is released, as the map clear begins
    a_clear_first: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) |-> !s_tready)
        else $error("request port ready during map clear");

    // A delivered result leaves the slot empty unless a new one is loaded
    a_slot_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !res_valid) |=> !m_tvalid)
        else $error("output slot not drained after hand-over");

endmodule

### rtl/cpa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpa_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module cpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/cpa_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpa_engine: page map sequencer
// Clears the map after reset, scans first-fit for allocations, marks the
// found run and walks freed runs, one map entry per cycle.
// ----------------------------------------------------------------------------
module cpa_engine (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [cpa_pkg::CNT_W-1:0]     map_size,
    input  logic [cpa_pkg::PAGE_W-1:0]    reserved_last,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  cpa_pkg::req_t                 req,
    output logic                          res_valid,
    input  logic                          res_free,
    output cpa_pkg::res_t                 res,
    output logic                          wr_en,
    output logic [cpa_pkg::PAGE_W-1:0]    wr_addr,
    output cpa_pkg::page_entry_t          wr_data,
    output logic [cpa_pkg::PAGE_W-1:0]    rd_addr,
    input  cpa_pkg::page_entry_t          rd_data
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_SCAN  = 6'b000100,
        S_MARK  = 6'b001000,
        S_WALK  = 6'b010000,
        S_RESP  = 6'b100000
    } state_t;

    state_t                      state_reg, state_next;
    logic [cpa_pkg::PAGE_W-1:0]  p_reg, p_next;
    logic [cpa_pkg::PAGE_W-1:0]  w_reg, w_next;
    logic [cpa_pkg::PAGE_W-1:0]  last_reg, last_next;
    logic [cpa_pkg::CNT_W-1:0]   k_reg, k_next;
    logic [cpa_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [1:0]                  status_reg, status_next;
    logic [cpa_pkg::PAGE_W-1:0]  base_reg, base_next;
    logic [cpa_pkg::CNT_W-1:0]   freed_reg, freed_next;

    logic [cpa_pkg::CNT_W-1:0]   p_plus1;
    logic                        taken;
    logic [cpa_pkg::CNT_W-1:0]   k_new;
    logic                        at_map_end;

    assign p_plus1    = {1'b0, p_reg} + cpa_pkg::CNT_W'(1);
    assign at_map_end = (p_plus1 == map_size);
    assign taken      = rd_data.used || (p_reg <= reserved_last);
    assign k_new      = taken ? '0 : k_reg + cpa_pkg::CNT_W'(1);

    assign res.status      = status_reg;
    assign res.first_page  = base_reg;
    assign res.pages_freed = freed_reg;

    always_comb begin
        state_next  = state_reg;
        p_next      = p_reg;
        w_next      = w_reg;
        last_next   = last_reg;
        k_next      = k_reg;
        cnt_next    = cnt_reg;
        status_next = status_reg;
        base_next   = base_reg;
        freed_next  = freed_reg;
        req_ready   = (state_reg == S_IDLE);
        res_valid   = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = p_reg;
        wr_data     = '0;
        rd_addr     = p_plus1[cpa_pkg::PAGE_W-1:0];

        case (state_reg)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = w_reg;
                w_next  = w_reg + cpa_pkg::PAGE_W'(1);
                if (w_reg == cpa_pkg::PAGE_LAST) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (req_valid) begin
                    status_next = cpa_pkg::ST_OK;
                    base_next   = '0;
                    freed_next  = '0;
                    cnt_next    = req.page_count;
                    k_next      = '0;
                    if (req.cmd == cpa_pkg::CMD_ALLOC) begin
                        rd_addr = '0;
                        p_next  = '0;
                        if (req.page_count == '0) begin
                            status_next = cpa_pkg::ST_BAD;
                            state_next  = S_RESP;
                        end else if (map_size == '0) begin
                            status_next = cpa_pkg::ST_NO_SPACE;
                            state_next  = S_RESP;
                        end else begin
                            state_next = S_SCAN;
                        end
                    end else begin
                        rd_addr = req.page_index;
                        p_next  = req.page_index;
                        if ({1'b0, req.page_index} >= map_size) begin
                            status_next = cpa_pkg::ST_BAD;
                            state_next  = S_RESP;
                        end else begin
                            state_next = S_WALK;
                        end
                    end
                end
            end
            S_SCAN: begin
                // rd_data holds page p_reg; page p_reg + 1 is fetched meanwhile
                if (k_new == cnt_reg) begin
                    w_next     = p_reg - k_new[cpa_pkg::PAGE_W-1:0] + cpa_pkg::PAGE_W'(1);
                    base_next  = p_reg - k_new[cpa_pkg::PAGE_W-1:0] + cpa_pkg::PAGE_W'(1);
                    last_next  = p_reg;
                    state_next = S_MARK;
                end else if (at_map_end) begin
                    status_next = cpa_pkg::ST_NO_SPACE;
                    state_next  = S_RESP;
                end else begin
                    k_next = k_new;
                    p_next = p_plus1[cpa_pkg::PAGE_W-1:0];
                end
            end
            S_MARK: begin
                wr_en             = 1'b1;
                wr_addr           = w_reg;
                wr_data.used      = 1'b1;
                wr_data.run_start = (w_reg == base_reg);
                wr_data.run_end   = (w_reg == last_reg);
                w_next            = w_reg + cpa_pkg::PAGE_W'(1);
                if (w_reg == last_reg) begin
                    state_next = S_RESP;
                end
            end
            S_WALK: begin
                wr_en      = 1'b1;
                wr_addr    = p_reg;
                freed_next = freed_reg + cpa_pkg::CNT_W'(1);
                if (rd_data.run_end || at_map_end) begin
                    state_next = S_RESP;
                end else begin
                    p_next = p_plus1[cpa_pkg::PAGE_W-1:0];
                end
            end
            S_RESP: begin
                res_valid = res_free;
                if (res_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            w_reg     <= '0;
        end else begin
            state_reg <= state_next;
            w_reg     <= w_next;
        end
        p_reg      <= p_next;
        last_reg   <= last_next;
        k_reg      <= k_next;
        cnt_reg    <= cnt_next;
        status_reg <= status_next;
        base_reg   <= base_next;
        freed_reg  <= freed_next;
    end

    // Map writes happen only while clearing, marking or walking
    a_write_states: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (state_reg == S_CLEAR || state_reg == S_MARK || state_reg == S_WALK))
        else $error("map write outside clear, mark or walk");

    // A scan in progress never holds a run as long as the request
    a_scan_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (k_reg < cnt_reg))
        else $error("scan run length reached request without marking");

    // Marking stays inside the found run
    a_mark_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MARK) |-> (w_reg >= base_reg && w_reg <= last_reg))
        else $error("mark pointer outside run");

    // Handing over a result returns the sequencer to idle
    a_resp_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |=> (state_reg == S_IDLE))
        else $error("result handed over without returning to idle");

endmodule

### tb/page_map_sb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_map_sb_pkg: page map predictor and result checker for the allocator
// Keeps its own copy of the page marks and registers, works out one result
// per accepted request and compares results from the block in order.
// ----------------------------------------------------------------------------
package page_map_sb_pkg;
    import cpa_pkg::*;

    class page_map_scoreboard;
        bit                used_mk  [MAP_DEPTH];
        bit                start_mk [MAP_DEPTH];
        bit                end_mk   [MAP_DEPTH];
        logic [CNT_W-1:0]  total_pages;
        logic [PAGE_W-1:0] reserved_last;
        res_t              pending_results [$];
        int unsigned       errors;

        function new();
            total_pages   = CNT_W'(1024);
            reserved_last = '0;
            errors        = 0;
        endfunction

        function void write_reg(logic addr, logic [CNT_W-1:0] value);
            if (addr == CFG_TOTAL_PAGES) begin
                total_pages = value;
            end else begin
                reserved_last = value[PAGE_W-1:0];
            end
        endfunction

        // Pages in the map: bounded by the map depth and by the 10 bit index fields
        function int unsigned map_pages();
            int unsigned n;
            n = total_pages;
            if (n > MAP_DEPTH) n = MAP_DEPTH;
            if (n > (1 << PAGE_W)) n = 1 << PAGE_W;
            return n;
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction

        function int unsigned pages_in_use();
            int unsigned n, total;
            n = map_pages();
            total = 0;
            for (int p = 0; p < n; p++) total += used_mk[p];
            return total;
        endfunction

        // Random page inside the map that carries a run start mark, or -1
        function int pick_run_start();
            int          starts [$];
            int unsigned n;
            n = map_pages();
            for (int p = 0; p < n; p++) if (start_mk[p]) starts.push_back(p);
            if (starts.size() == 0) return -1;
            return starts[$urandom_range(starts.size() - 1)];
        endfunction

        function void predict_request(logic cmd, logic [CNT_W-1:0] count,
                                      logic [PAGE_W-1:0] page_idx);
            res_t        want;
            int unsigned n, i, k, first, freed;
            bit          stop;
            n    = map_pages();
            want = '0;
            want.status = ST_OK;
            if (cmd == CMD_ALLOC) begin
                if (count == 0) begin
                    want.status = ST_BAD;
                end else begin
                    // First fit: restart the run on every taken page
                    i = 0;
                    k = 0;
                    while (i < n && k < count) begin
                        if (used_mk[i] || i <= reserved_last) k = 0;
                        else k++;
                        i++;
                    end
                    if (k != count) begin
                        want.status = ST_NO_SPACE;
                    end else begin
                        first = i - k;
                        start_mk[first] = 1'b1;
                        end_mk[i-1]     = 1'b1;
                        for (int m = first; m < i; m++) used_mk[m] = 1'b1;
                        want.first_page = PAGE_W'(first);
                    end
                end
            end else if (page_idx >= n) begin
                want.status = ST_BAD;
            end else begin
                // Clear up to the next end mark, or stop at the last page
                i     = page_idx;
                freed = 0;
                stop  = 1'b0;
                while (!stop) begin
                    stop        = end_mk[i];
                    used_mk[i]  = 1'b0;
                    start_mk[i] = 1'b0;
                    end_mk[i]   = 1'b0;
                    freed++;
                    i++;
                    if (i >= n) stop = 1'b1;
                end
                want.pages_freed = CNT_W'(freed);
            end
            pending_results.push_back(want);
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, field, want, got);
            end
        endfunction

        function void check_result(logic [23:0] data);
            res_t got, want;
            got.status      = data[1:0];
            got.first_page  = data[11:2];
            got.pages_freed = data[22:12];
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, %s %0d base %0d freed %0d",
                         $time, "actual status", got.status, got.first_page,
                         got.pages_freed);
                return;
            end
            want = pending_results.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("first_page", want.first_page, got.first_page);
            compare_field("pages_freed", want.pages_freed, got.pages_freed);
        endfunction
    endclass

endpackage

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the contiguous page allocator
// Directed requests cover the map edges and the special cases, then three
// random phases of allocate/free traffic run under changing map settings
// and handshake gaps; every result is checked in order against a predictor.
// ----------------------------------------------------------------------------
module tb_top;
    import cpa_pkg::*;
    import page_map_sb_pkg::*;

    // All 581 requests, plus stalls and the clearing sweep after reset,
    // stay far below this limit.
    localparam int unsigned CYCLE_LIMIT      = 6_000_000;
    localparam int unsigned HOLD_CYCLES      = 1500;
    localparam int unsigned RANDOM_PER_PHASE = 186;
    localparam int unsigned DRAIN_CYCLES     = 64;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // [10:0] page_count, [20:11] page_index, rest zero
    logic        s_tuser;   // [0] cmd
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [1:0] status, [11:2] first_page, [22:12] pages_freed
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_addr;
    logic [10:0] cfg_data;

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    bit          hold_req;
    int unsigned cycles;

    page_map_scoreboard sb = new();

    contiguous_page_allocator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Watchdog
    always @(posedge aclk) begin
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Check every result transaction at the edge that takes it
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // Result side: random stalls, plus one long hold-off on request
    initial begin : result_sink
        bit held;
        held     = 1'b0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !held) begin
                held     = 1'b1;
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            m_tready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one request; valid stays high after acceptance until the next call
    task automatic send_request(input logic cmd, input int unsigned count,
                                input int unsigned page_idx);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = {3'b000, page_idx[PAGE_W-1:0], count[CNT_W-1:0]};
        do @(posedge aclk); while (!s_tready);
        sb.predict_request(cmd, count[CNT_W-1:0], page_idx[PAGE_W-1:0]);
    endtask

    task automatic write_reg(input logic addr, input int unsigned value);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_addr  = addr;
        cfg_data  = value[10:0];
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(addr, value[10:0]);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Drop valid and hold until every expected result is in
    task automatic wait_drained(input int unsigned extra);
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    // Mostly frees of live runs and small allocates; a little noise
    task automatic send_random_request();
        int unsigned roll, n, count;
        int          run_base;
        roll     = $urandom_range(99);
        n        = sb.map_pages();
        run_base = sb.pick_run_start();
        if (roll < 8) begin
            case ($urandom_range(2))
                0: send_request(CMD_ALLOC, $urandom_range(2047), $urandom_range(1023));
                1: send_request(CMD_ALLOC, 0, $urandom_range(1023));
                default: send_request(CMD_FREE, $urandom_range(2047), $urandom_range(1023));
            endcase
        end else if (run_base >= 0 && (roll < 42 || 2 * sb.pages_in_use() > n)) begin
            send_request(CMD_FREE, $urandom_range(2047), run_base);
        end else begin
            roll = $urandom_range(99);
            if (roll < 70) count = $urandom_range(8, 1);
            else if (roll < 95) count = $urandom_range(64, 9);
            else count = $urandom_range(1024, 65);
            send_request(CMD_ALLOC, count, $urandom_range(1023));
        end
    endtask

    initial begin : stimulus
        aclk          = 1'b0;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = CMD_ALLOC;
        cfg_valid     = 1'b0;
        cfg_addr      = CFG_TOTAL_PAGES;
        cfg_data      = '0;
        hold_req      = 1'b0;
        send_idle_pct = 17;
        recv_idle_pct = 70;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reset settings: 1024 pages, page 0 reserved
        send_request(CMD_ALLOC, 0, 0);          // zero count
        send_request(CMD_ALLOC, 2047, 1023);    // larger than the map
        send_request(CMD_FREE, 0, 0);           // reserved page, no end mark: whole map
        send_request(CMD_ALLOC, 1, 0);
        send_request(CMD_ALLOC, 1023, 0);       // one page short
        send_request(CMD_FREE, 0, 1);
        send_request(CMD_ALLOC, 1023, 0);       // exact fill
        send_request(CMD_ALLOC, 1, 0);          // map full
        send_request(CMD_FREE, 0, 1023);        // last page
        send_request(CMD_FREE, 0, 1);           // end mark gone: walk to map end
        send_request(CMD_ALLOC, 3, 0);
        send_request(CMD_ALLOC, 5, 0);
        send_request(CMD_FREE, 0, 2);           // from inside a run
        send_request(CMD_ALLOC, 2, 0);
        send_request(CMD_FREE, 0, 4);
        send_request(CMD_FREE, 0, 600);         // already free page

        // Whole map reserved
        wait_drained(8);
        write_reg(CFG_RESERVED_LAST, 1023);
        send_request(CMD_ALLOC, 1, 0);
        send_request(CMD_FREE, 0, 1);

        // Empty map
        wait_drained(8);
        write_reg(CFG_TOTAL_PAGES, 0);
        send_request(CMD_ALLOC, 1, 0);
        send_request(CMD_FREE, 0, 0);

        // Single page map; marks above it must survive
        wait_drained(8);
        write_reg(CFG_TOTAL_PAGES, 1);
        write_reg(CFG_RESERVED_LAST, 0);
        send_request(CMD_ALLOC, 1, 0);
        send_request(CMD_FREE, 0, 0);
        send_request(CMD_FREE, 0, 1);           // index past the map

        // Random phase 1: full map, sender mostly busy, receiver mostly stalled
        wait_drained(8);
        write_reg(CFG_TOTAL_PAGES, 1024);
        write_reg(CFG_RESERVED_LAST, 0);
        repeat (RANDOM_PER_PHASE) send_random_request();

        // Random phase 2: smaller map, idling the other way round
        wait_drained(8);
        send_idle_pct = 70;
        recv_idle_pct = 17;
        write_reg(CFG_TOTAL_PAGES, 384);
        write_reg(CFG_RESERVED_LAST, 31);
        repeat (RANDOM_PER_PHASE) send_random_request();

        // Random phase 3: no idling, one long receiver hold-off to back up the block
        wait_drained(8);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_TOTAL_PAGES, 1000);
        write_reg(CFG_RESERVED_LAST, 5);
        repeat (10) send_random_request();
        hold_req = 1'b1;
        repeat (RANDOM_PER_PHASE - 10) send_random_request();

        wait_drained(DRAIN_CYCLES);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/cpa_pkg.sv
rtl/cpa_ram.sv
rtl/cpa_engine.sv
rtl/contiguous_page_allocator.sv
tb/page_map_sb_pkg.sv
tb/tb_top.sv
